>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks on the rasteriser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// antecedent at an edge forces the consequent at the same edge
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/trz_pkg.sv
// ----------------------------------------------------------------------------
// trz_pkg
// types and fixed widths shared by the rasteriser front end, queue and back end
// ----------------------------------------------------------------------------
package trz_pkg;

   // coordinate and coefficient width (covers differences of two vertices)
   localparam int CW    = 12;
   // edge function and doubled area width
   localparam int EW    = 26;
   // interpolated depth numerator width
   localparam int NW    = 36;
   // numerator step width
   localparam int DNW   = 24;
   // row base address width
   localparam int BW    = 22;
   // multiply accumulator width
   localparam int ACCW  = EW + CW + 2;
   localparam int CNTW  = 19;
   localparam int ZW    = 8;
   localparam int COLW  = 24;
   localparam int IDXW  = 18;
   localparam int CRDW  = 11;

   localparam logic [CNTW-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      KIND_DRAW = 2'd0,
      KIND_READ = 2'd1,
      KIND_CULL = 2'd2
   } kind_type;

   // fully set up item handed from front end to back end
   typedef struct packed {
      kind_type               kind;
      logic [IDXW-1:0]        index;
      logic [COLW-1:0]        color;
      logic signed [CW-1:0]   x0;
      logic signed [CW-1:0]   x1;
      logic signed [CW-1:0]   y0;
      logic signed [CW-1:0]   y1;
      logic signed [EW-1:0]   a2;
      logic signed [EW-1:0]   ea;
      logic signed [EW-1:0]   eb;
      logic signed [EW-1:0]   ec;
      logic signed [CW-1:0]   dxa;
      logic signed [CW-1:0]   dxb;
      logic signed [CW-1:0]   dxc;
      logic signed [CW-1:0]   dya;
      logic signed [CW-1:0]   dyb;
      logic signed [CW-1:0]   dyc;
      logic signed [NW-1:0]   n0;
      logic signed [DNW-1:0]  dnx;
      logic signed [DNW-1:0]  dny;
      logic [BW-1:0]          base;
   } job_type;

endpackage

>>> hw/rtl/trz_front.sv
// ----------------------------------------------------------------------------
// trz_front
// accepts request beats, classifies them and sets up triangle coefficients
// with one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
module trz_front #(
   parameter int SCREEN_WIDTH  = 512,
   parameter int SCREEN_HEIGHT = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic signed [trz_pkg::CRDW-1:0] req_vert_a_x,
   input  logic signed [trz_pkg::CRDW-1:0] req_vert_a_y,
   input  logic [trz_pkg::ZW-1:0]        req_vert_a_depth,
   input  logic signed [trz_pkg::CRDW-1:0] req_vert_b_x,
   input  logic signed [trz_pkg::CRDW-1:0] req_vert_b_y,
   input  logic [trz_pkg::ZW-1:0]        req_vert_b_depth,
   input  logic signed [trz_pkg::CRDW-1:0] req_vert_c_x,
   input  logic signed [trz_pkg::CRDW-1:0] req_vert_c_y,
   input  logic [trz_pkg::ZW-1:0]        req_vert_c_depth,
   input  logic [trz_pkg::COLW-1:0]      req_fill_color,
   input  logic [trz_pkg::IDXW-1:0]      req_pixel_index,
   input  logic                          clr_done,
   output logic                          job_valid,
   input  logic                          job_ready,
   output trz_pkg::job_type              job
);

   localparam int CW   = trz_pkg::CW;
   localparam int EW   = trz_pkg::EW;
   localparam int ACCW = trz_pkg::ACCW;
   localparam int LAST_STEP = 16;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_BOX  = 4'b0010,
      F_MUL  = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   trz_pkg::kind_type kind_ff;

   logic signed [trz_pkg::CRDW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [trz_pkg::ZW-1:0]          az_ff, bz_ff, cz_ff;
   logic [trz_pkg::COLW-1:0]        color_ff;
   logic [trz_pkg::IDXW-1:0]        index_ff;
   logic signed [CW-1:0]            x0_ff, x1_ff, y0_ff, y1_ff;
   logic signed [ACCW-1:0]          acc_ff, acc_in;
   logic signed [EW-1:0]            a2_ff, ea_ff, eb_ff, ec_ff;
   logic signed [trz_pkg::NW-1:0]   n0_ff;
   logic signed [trz_pkg::DNW-1:0]  dnx_ff, dny_ff;
   logic [trz_pkg::BW-1:0]          base_ff;

   logic accept;
   logic signed [CW-1:0] axw, ayw, bxw, byw, cxw, cyw, azw, bzw, czw;
   logic signed [CW-1:0] mnx, mxx, mny, mxy;
   logic signed [EW-1:0] opa;
   logic signed [CW-1:0] opb;
   logic signed [EW+CW-1:0] prod;
   logic first, sub;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == F_IDLE) && clr_done;
   assign job_valid = (state_ff == F_PUSH);

   // widened vertex values
   assign axw = CW'(ax_ff);
   assign ayw = CW'(ay_ff);
   assign bxw = CW'(bx_ff);
   assign byw = CW'(by_ff);
   assign cxw = CW'(cx_ff);
   assign cyw = CW'(cy_ff);
   assign azw = $signed(CW'(az_ff));
   assign bzw = $signed(CW'(bz_ff));
   assign czw = $signed(CW'(cz_ff));

   // bounding box extremes
   always_comb begin
      mnx = (axw < bxw) ? axw : bxw;
      mnx = (mnx < cxw) ? mnx : cxw;
      mxx = (axw > bxw) ? axw : bxw;
      mxx = (mxx > cxw) ? mxx : cxw;
      mny = (ayw < byw) ? ayw : byw;
      mny = (mny < cyw) ? mny : cyw;
      mxy = (ayw > byw) ? ayw : byw;
      mxy = (mxy > cyw) ? mxy : cyw;
   end

   // operand selection for the setup sequence
   always_comb begin
      opa   = '0;
      opb   = '0;
      first = 1'b0;
      sub   = 1'b0;
      case (step_ff)
         // doubled area
         5'd0:  begin opa = EW'(bxw - axw);   opb = cyw - ayw;   first = 1'b1; end
         5'd1:  begin opa = EW'(byw - ayw);   opb = cxw - axw;   sub = 1'b1;   end
         // edge values at the box corner
         5'd2:  begin opa = EW'(bxw - x0_ff); opb = cyw - y0_ff; first = 1'b1; end
         5'd3:  begin opa = EW'(byw - y0_ff); opb = cxw - x0_ff; sub = 1'b1;   end
         5'd4:  begin opa = EW'(cxw - x0_ff); opb = ayw - y0_ff; first = 1'b1; end
         5'd5:  begin opa = EW'(cyw - y0_ff); opb = axw - x0_ff; sub = 1'b1;   end
         5'd6:  begin opa = EW'(axw - x0_ff); opb = byw - y0_ff; first = 1'b1; end
         5'd7:  begin opa = EW'(ayw - y0_ff); opb = bxw - x0_ff; sub = 1'b1;   end
         // depth numerator at the corner
         5'd8:  begin opa = ea_ff;            opb = azw;         first = 1'b1; end
         5'd9:  begin opa = eb_ff;            opb = bzw;                       end
         5'd10: begin opa = ec_ff;            opb = czw;                       end
         // numerator step along x
         5'd11: begin opa = EW'(byw - cyw);   opb = azw;         first = 1'b1; end
         5'd12: begin opa = EW'(cyw - ayw);   opb = bzw;                       end
         5'd13: begin opa = EW'(ayw - byw);   opb = czw;                       end
         // numerator step along y
         5'd14: begin opa = EW'(cxw - bxw);   opb = azw;         first = 1'b1; end
         5'd15: begin opa = EW'(axw - cxw);   opb = bzw;                       end
         5'd16: begin opa = EW'(bxw - axw);   opb = czw;                       end
         default: begin end
      endcase
   end

   assign prod   = opa * opb;
   assign acc_in = (first ? '0 : acc_ff) + (sub ? -ACCW'(prod) : ACCW'(prod));

   // control sequencing
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         F_IDLE: begin
            step_in = '0;
            if (accept) state_in = req_op ? F_PUSH : F_BOX;
         end
         F_BOX: state_in = F_MUL;
         F_MUL: begin
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd1 && acc_in < $signed(ACCW'(2))) state_in = F_PUSH;
            else if (step_ff == 5'(LAST_STEP)) state_in = F_PUSH;
         end
         F_PUSH: if (job_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // capture of the request beat and setup results
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_op ? trz_pkg::KIND_READ : trz_pkg::KIND_DRAW;
         ax_ff    <= req_vert_a_x;
         ay_ff    <= req_vert_a_y;
         az_ff    <= req_vert_a_depth;
         bx_ff    <= req_vert_b_x;
         by_ff    <= req_vert_b_y;
         bz_ff    <= req_vert_b_depth;
         cx_ff    <= req_vert_c_x;
         cy_ff    <= req_vert_c_y;
         cz_ff    <= req_vert_c_depth;
         color_ff <= req_fill_color;
         index_ff <= req_pixel_index;
      end
      if (state_ff == F_BOX) begin
         x0_ff <= (mnx < 0) ? '0 : mnx;
         y0_ff <= (mny < 0) ? '0 : mny;
         x1_ff <= (mxx > $signed(CW'(SCREEN_WIDTH - 1)))  ? $signed(CW'(SCREEN_WIDTH - 1))  : mxx;
         y1_ff <= (mxy > $signed(CW'(SCREEN_HEIGHT - 1))) ? $signed(CW'(SCREEN_HEIGHT - 1)) : mxy;
      end
      if (state_ff == F_MUL) begin
         acc_ff <= acc_in;
         case (step_ff)
            5'd0: base_ff <= trz_pkg::BW'($unsigned(y0_ff)) *
                             trz_pkg::BW'(SCREEN_WIDTH);
            5'd1: begin
               a2_ff <= EW'(acc_in);
               if (acc_in < $signed(ACCW'(2))) kind_ff <= trz_pkg::KIND_CULL;
            end
            5'd3:  ea_ff  <= EW'(acc_in);
            5'd5:  eb_ff  <= EW'(acc_in);
            5'd7:  ec_ff  <= EW'(acc_in);
            5'd10: n0_ff  <= trz_pkg::NW'(acc_in);
            5'd13: dnx_ff <= trz_pkg::DNW'(acc_in);
            5'd16: dny_ff <= trz_pkg::DNW'(acc_in);
            default: begin end
         endcase
      end
   end

   // outgoing job
   always_comb begin
      job.kind  = kind_ff;
      job.index = index_ff;
      job.color = color_ff;
      job.x0    = x0_ff;
      job.x1    = x1_ff;
      job.y0    = y0_ff;
      job.y1    = y1_ff;
      job.a2    = a2_ff;
      job.ea    = ea_ff;
      job.eb    = eb_ff;
      job.ec    = ec_ff;
      job.dxa   = byw - cyw;
      job.dya   = cxw - bxw;
      job.dxb   = cyw - ayw;
      job.dyb   = axw - cxw;
      job.dxc   = ayw - byw;
      job.dyc   = bxw - axw;
      job.n0    = n0_ff;
      job.dnx   = dnx_ff;
      job.dny   = dny_ff;
      job.base  = base_ff;
   end

endmodule

>>> hw/rtl/trz_queue.sv
// ----------------------------------------------------------------------------
// trz_queue
// two-entry job queue between setup front end and pixel back end
// ----------------------------------------------------------------------------
module trz_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  trz_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output trz_pkg::job_type out_job
);

   trz_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = entry_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_job;
   end

endmodule

>>> hw/rtl/trz_back.sv
// ----------------------------------------------------------------------------
// trz_back
// scans the bounding box, divides out depth, runs the depth test against the
// pixel store and answers read beats
// ----------------------------------------------------------------------------
module trz_back #(
   parameter int SCREEN_WIDTH  = 512,
   parameter int SCREEN_HEIGHT = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   output logic                           job_ready,
   input  trz_pkg::job_type               job,
   output logic                           clr_done,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [trz_pkg::CNTW-1:0]       rsp_pixels_written,
   output logic                           rsp_culled,
   output logic [trz_pkg::COLW-1:0]       rsp_read_color,
   output logic [trz_pkg::ZW-1:0]         rsp_read_depth
);

   localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW   = $clog2(STORE_SIZE);
   localparam int CW   = trz_pkg::CW;
   localparam int EW   = trz_pkg::EW;
   localparam int NW   = trz_pkg::NW;
   localparam int ZW   = trz_pkg::ZW;
   localparam int DW   = trz_pkg::COLW + ZW;

   typedef enum logic [7:0] {
      B_CLEAR  = 8'b0000_0001,
      B_IDLE   = 8'b0000_0010,
      B_DECODE = 8'b0000_0100,
      B_PIX    = 8'b0000_1000,
      B_DIV    = 8'b0001_0000,
      B_WR     = 8'b0010_0000,
      B_OUT    = 8'b0100_0000,
      B_SPARE  = 8'b1000_0000
   } bstate_type;

   bstate_type state_ff, state_in;
   trz_pkg::job_type job_ff;
   logic [AW-1:0] clr_cnt_ff;

   // pixel store, colour above depth
   logic [DW-1:0] mem [STORE_SIZE];
   logic [DW-1:0] rd_data_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [DW-1:0] wr_data;

   logic signed [CW-1:0] x_ff, y_ff;
   logic signed [EW-1:0] ea_ff, eb_ff, ec_ff, cea_ff, ceb_ff, cec_ff;
   logic signed [NW-1:0] n_ff, cn_ff;
   logic [AW-1:0]        addr_ff, caddr_ff;
   logic [NW-1:0]        rem_ff, dsr_ff;
   logic [ZW-1:0]        quo_ff;
   logic [2:0]           bit_cnt_ff;
   logic [trz_pkg::CNTW-1:0] count_ff;
   logic                 in_range_ff;

   logic covered, adv, row_end, box_end, pass, load_rsp;
   logic signed [EW-1:0] nea, neb, nec;
   logic signed [NW-1:0] nn;
   logic [AW-1:0]        naddr;

   assign clr_done  = (state_ff != B_CLEAR);
   assign job_ready = (state_ff == B_IDLE);
   assign covered   = !ea_ff[EW-1] && !eb_ff[EW-1] && !ec_ff[EW-1];
   assign pass      = (quo_ff > rd_data_ff[ZW-1:0]);
   assign row_end   = (y_ff == job_ff.y1);
   assign box_end   = row_end && (x_ff == job_ff.x1);
   assign adv       = ((state_ff == B_PIX) && !covered) || (state_ff == B_WR);
   assign load_rsp  = (state_ff == B_OUT) && (!rsp_valid || rsp_ready);

   // next column start values
   assign nea   = cea_ff + EW'(job_ff.dxa);
   assign neb   = ceb_ff + EW'(job_ff.dxb);
   assign nec   = cec_ff + EW'(job_ff.dxc);
   assign nn    = cn_ff + NW'(job_ff.dnx);
   assign naddr = caddr_ff + AW'(1);

   // store port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = addr_ff;
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = {job_ff.color, quo_ff};
      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
         end
         B_DECODE: begin
            rd_en   = (job_ff.kind == trz_pkg::KIND_READ);
            rd_addr = AW'(job_ff.index);
         end
         B_PIX: rd_en = covered;
         B_WR:  wr_en = pass;
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // state sequencing
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: if (clr_cnt_ff == AW'(STORE_SIZE - 1)) state_in = B_IDLE;
         B_IDLE:  if (job_valid) state_in = B_DECODE;
         B_DECODE: begin
            if (job_ff.kind == trz_pkg::KIND_DRAW &&
                job_ff.x0 <= job_ff.x1 && job_ff.y0 <= job_ff.y1) state_in = B_PIX;
            else state_in = B_OUT;
         end
         B_PIX: begin
            if (covered) state_in = B_DIV;
            else if (box_end) state_in = B_OUT;
         end
         B_DIV: if (bit_cnt_ff == 3'd7) state_in = B_WR;
         B_WR:  state_in = box_end ? B_OUT : B_PIX;
         B_OUT: if (load_rsp) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_CLEAR;
         clr_cnt_ff <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (load_rsp) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // scan, divide and count datapath
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && job_valid) job_ff <= job;
      if (state_ff == B_DECODE) begin
         count_ff    <= '0;
         in_range_ff <= (32'(job_ff.index) < 32'(STORE_SIZE));
         x_ff        <= job_ff.x0;
         y_ff        <= job_ff.y0;
         ea_ff       <= job_ff.ea;
         eb_ff       <= job_ff.eb;
         ec_ff       <= job_ff.ec;
         n_ff        <= job_ff.n0;
         cea_ff      <= job_ff.ea;
         ceb_ff      <= job_ff.eb;
         cec_ff      <= job_ff.ec;
         cn_ff       <= job_ff.n0;
         addr_ff     <= AW'(job_ff.base) + AW'($unsigned(job_ff.x0));
         caddr_ff    <= AW'(job_ff.base) + AW'($unsigned(job_ff.x0));
      end
      if (state_ff == B_PIX && covered) begin
         rem_ff     <= $unsigned(n_ff);
         dsr_ff     <= NW'($unsigned(job_ff.a2)) << (ZW - 1);
         quo_ff     <= '0;
         bit_cnt_ff <= '0;
      end
      // one quotient bit per cycle
      if (state_ff == B_DIV) begin
         if (rem_ff >= dsr_ff) begin
            rem_ff <= rem_ff - dsr_ff;
            quo_ff <= {quo_ff[ZW-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[ZW-2:0], 1'b0};
         end
         dsr_ff     <= dsr_ff >> 1;
         bit_cnt_ff <= bit_cnt_ff + 3'd1;
      end
      if (state_ff == B_WR && pass && count_ff != trz_pkg::COUNT_MAX)
         count_ff <= count_ff + trz_pkg::CNTW'(1);
      // step down the column, or over to the next one
      if (adv && !box_end) begin
         if (row_end) begin
            x_ff     <= x_ff + CW'(1);
            y_ff     <= job_ff.y0;
            cea_ff   <= nea;
            ceb_ff   <= neb;
            cec_ff   <= nec;
            cn_ff    <= nn;
            caddr_ff <= naddr;
            ea_ff    <= nea;
            eb_ff    <= neb;
            ec_ff    <= nec;
            n_ff     <= nn;
            addr_ff  <= naddr;
         end else begin
            y_ff    <= y_ff + CW'(1);
            ea_ff   <= ea_ff + EW'(job_ff.dya);
            eb_ff   <= eb_ff + EW'(job_ff.dyb);
            ec_ff   <= ec_ff + EW'(job_ff.dyc);
            n_ff    <= n_ff + NW'(job_ff.dny);
            addr_ff <= addr_ff + AW'(SCREEN_WIDTH);
         end
      end
      // result register
      if (load_rsp) begin
         rsp_pixels_written <= (job_ff.kind == trz_pkg::KIND_DRAW) ? count_ff : '0;
         rsp_culled         <= (job_ff.kind == trz_pkg::KIND_CULL);
         if (job_ff.kind == trz_pkg::KIND_READ && in_range_ff) begin
            rsp_read_color <= rd_data_ff[DW-1:ZW];
            rsp_read_depth <= rd_data_ff[ZW-1:0];
         end else begin
            rsp_read_color <= '0;
            rsp_read_depth <= '0;
         end
      end
   end

endmodule

>>> hw/rtl/triangle_raster_zbuffer_core.sv
// ----------------------------------------------------------------------------
// triangle_raster_zbuffer_core
// triangle rasteriser with depth-tested colour and depth store
// ----------------------------------------------------------------------------
// After reset the block sweeps all SCREEN_WIDTH*SCREEN_HEIGHT entries of the
// pixel store (262144 at the defaults) to zero, one entry per cycle; no request
// beat is taken until that pass ends. In setup of a draw beat, one shared
// multiply-accumulate unit forms area, edge and depth-slope terms over 17
// steps; a culled draw stops after the area steps. The back end then walks
// the clipped bounding box one uncovered pixel per cycle, while each covered
// pixel goes through edge test, bit-serial depth divide and store write. A
// two-entry queue lets setup of the next draw overlap the scan of the current
// one, and a finished result waits in an output register without holding up
// new requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_raster_zbuffer_core #(
   parameter int SCREEN_WIDTH  = 512,
   parameter int SCREEN_HEIGHT = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic signed [trz_pkg::CRDW-1:0]  req_vert_a_x,
   input  logic signed [trz_pkg::CRDW-1:0]  req_vert_a_y,
   input  logic [trz_pkg::ZW-1:0]           req_vert_a_depth,
   input  logic signed [trz_pkg::CRDW-1:0]  req_vert_b_x,
   input  logic signed [trz_pkg::CRDW-1:0]  req_vert_b_y,
   input  logic [trz_pkg::ZW-1:0]           req_vert_b_depth,
   input  logic signed [trz_pkg::CRDW-1:0]  req_vert_c_x,
   input  logic signed [trz_pkg::CRDW-1:0]  req_vert_c_y,
   input  logic [trz_pkg::ZW-1:0]           req_vert_c_depth,
   input  logic [trz_pkg::COLW-1:0]         req_fill_color,
   input  logic [trz_pkg::IDXW-1:0]         req_pixel_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [trz_pkg::CNTW-1:0]         rsp_pixels_written,
   output logic                             rsp_culled,
   output logic [trz_pkg::COLW-1:0]         rsp_read_color,
   output logic [trz_pkg::ZW-1:0]           rsp_read_depth
);

   logic             clr_done;
   logic             fq_valid, fq_ready, qb_valid, qb_ready;
   trz_pkg::job_type fq_job, qb_job;

   // setup front end
   trz_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_vert_a_x     (req_vert_a_x),
      .req_vert_a_y     (req_vert_a_y),
      .req_vert_a_depth (req_vert_a_depth),
      .req_vert_b_x     (req_vert_b_x),
      .req_vert_b_y     (req_vert_b_y),
      .req_vert_b_depth (req_vert_b_depth),
      .req_vert_c_x     (req_vert_c_x),
      .req_vert_c_y     (req_vert_c_y),
      .req_vert_c_depth (req_vert_c_depth),
      .req_fill_color   (req_fill_color),
      .req_pixel_index  (req_pixel_index),
      .clr_done         (clr_done),
      .job_valid        (fq_valid),
      .job_ready        (fq_ready),
      .job              (fq_job)
   );

   // job queue
   trz_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_job   (qb_job)
   );

   // pixel back end and store
   trz_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (qb_valid),
      .job_ready          (qb_ready),
      .job                (qb_job),
      .clr_done           (clr_done),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixels_written (rsp_pixels_written),
      .rsp_culled         (rsp_culled),
      .rsp_read_color     (rsp_read_color),
      .rsp_read_depth     (rsp_read_depth)
   );

   // checks
   `ASSERT_IMPLIES(a_no_req_during_clear, clock, reset, req_ready, clr_done, "request taken during store clear")
   `ASSERT_NEVER(a_culled_clean, clock, reset, rsp_valid && rsp_culled && (rsp_pixels_written != '0 || rsp_read_color != '0 || rsp_read_depth != '0), "culled result carries data")
   `ASSERT_IMPLIES(a_read_only_data, clock, reset, rsp_valid && (rsp_read_color != '0 || rsp_read_depth != '0), !rsp_culled && rsp_pixels_written == '0, "read data on a draw result")

endmodule
